// File: src/wss_pkg.sv
// shared types, constants and helpers of the weighted 3x3 smoothing block
package wss_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int PIX_W      = 8;
  localparam int FW_W       = 6;
  localparam int FH_W       = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(8);
  localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(8);

  // weighted sum of a full 3x3 neighborhood is at most 88 * 255
  localparam int SUM_W       = 15;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // ceil(2^24 / d): exact truncating quotient for any sum below 2^15
  localparam logic [RECIP_W-1:0] RECIP_88 = RECIP_W'(190651);
  localparam logic [RECIP_W-1:0] RECIP_64 = RECIP_W'(262144);
  localparam logic [RECIP_W-1:0] RECIP_47 = RECIP_W'(356963);

  localparam int EVQ_DEPTH = 4;
  localparam int OFQ_DEPTH = 4;

  typedef enum logic [1:0] {
    DIV_88,
    DIV_64,
    DIV_47
  } div_e;

  // window[row][col]: rows r-2, r-1, r; cols c-2, c-1, c
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t win;
    logic emit_a;    // output centered one row up, one column left
    logic emit_b;    // row end: output centered one row up, this column
    logic last_row;  // each output is followed by the one below it
    logic top_ok;    // a row exists above the upper center
    logic lft_ok;    // a column exists left of the left center
  } event_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             frame_last;
  } result_t;

  function automatic logic [RECIP_W-1:0] recip(div_e d);
    logic [RECIP_W-1:0] m;
    case (d)
      DIV_88:  m = RECIP_88;
      DIV_64:  m = RECIP_64;
      DIV_47:  m = RECIP_47;
      default: m = RECIP_88;
    endcase
    return m;
  endfunction

endpackage

// File: src/wss_ram.sv
// generic single write port ram with registered read
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wss_front.sv
// front end: config, raster position, line stores, window and output classification
module wss_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [wss_pkg::PIX_W-1:0]       pixel_in_i,
  input  logic                            cfg_we_i,
  input  logic [wss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wss_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            evq_full_i,
  output logic                            ev_push_o,
  output wss_pkg::event_t                 ev_o
);

  logic [wss_pkg::FW_W-1:0]  width_q;
  logic [wss_pkg::FH_W-1:0]  height_q;
  logic [wss_pkg::COL_W-1:0] col_q;
  logic [wss_pkg::FH_W-1:0]  row_q;

  logic [wss_pkg::FW_W-1:0]  w_eff;
  logic [wss_pkg::FH_W-1:0]  h_eff;
  logic [wss_pkg::COL_W-1:0] c_cur;
  logic [wss_pkg::FH_W-1:0]  r_cur;
  logic [wss_pkg::FW_W-1:0]  c_inc;
  logic [wss_pkg::FH_W:0]    r_inc;

  logic accept;

  // held pixel waiting for its line store data
  logic                      s1_v_q;
  logic [wss_pkg::PIX_W-1:0] s1_pix_q;
  logic [wss_pkg::COL_W-1:0] s1_col_q;
  logic                      s1_emit_a_q, s1_emit_b_q, s1_last_q, s1_top_q, s1_lft_q;
  logic                      s1_go;

  logic [wss_pkg::PIX_W-1:0] top_rd, mid_rd;
  wss_pkg::win_t             win_q, win_d;

  always_comb begin
    if (width_q < wss_pkg::FW_W'(2)) begin
      w_eff = wss_pkg::FW_W'(2);
    end else if (width_q > wss_pkg::FW_W'(wss_pkg::MAX_WIDTH)) begin
      w_eff = wss_pkg::FW_W'(wss_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < wss_pkg::FH_W'(2)) ? wss_pkg::FH_W'(2) : height_q;
    c_cur = (wss_pkg::FW_W'(col_q) >= w_eff) ? '0 : col_q;
    r_cur = (row_q >= h_eff) ? '0 : row_q;
    c_inc = wss_pkg::FW_W'(c_cur) + wss_pkg::FW_W'(1);
    r_inc = {1'b0, r_cur} + (wss_pkg::FH_W + 1)'(1);
  end

  assign s1_go  = s1_v_q & (~(s1_emit_a_q | s1_emit_b_q) | ~evq_full_i);
  assign full   = s1_v_q & ~s1_go;
  assign accept = push & ~full;

  wss_ram #(
    .WIDTH (wss_pkg::PIX_W),
    .DEPTH (wss_pkg::MAX_WIDTH)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (top_rd)
  );

  wss_ram #(
    .WIDTH (wss_pkg::PIX_W),
    .DEPTH (wss_pkg::MAX_WIDTH)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (mid_rd)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = top_rd;
    win_d[1][2] = mid_rd;
    win_d[2][2] = s1_pix_q;
  end

  assign ev_push_o   = s1_go & (s1_emit_a_q | s1_emit_b_q);
  assign ev_o.win      = win_d;
  assign ev_o.emit_a   = s1_emit_a_q;
  assign ev_o.emit_b   = s1_emit_b_q;
  assign ev_o.last_row = s1_last_q;
  assign ev_o.top_ok   = s1_top_q;
  assign ev_o.lft_ok   = s1_lft_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wss_pkg::RESET_WIDTH;
      height_q <= wss_pkg::RESET_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      win_q    <= '0;
    end else begin
      if (s1_go || !s1_v_q) begin
        s1_v_q <= accept;
      end
      if (s1_go) begin
        win_q <= win_d;
      end
      if (accept) begin
        if (c_inc >= w_eff) begin
          col_q <= '0;
          row_q <= (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[wss_pkg::FH_W-1:0];
        end else begin
          col_q <= c_inc[wss_pkg::COL_W-1:0];
          row_q <= r_cur;
        end
      end
      if (cfg_we_i && cfg_idx_i == wss_pkg::REG_FRAME_WIDTH) begin
        width_q <= cfg_wdata_i[wss_pkg::FW_W-1:0];
        col_q   <= '0;
        row_q   <= '0;
      end else if (cfg_we_i && cfg_idx_i == wss_pkg::REG_FRAME_HEIGHT) begin
        height_q <= cfg_wdata_i[wss_pkg::FH_W-1:0];
        col_q    <= '0;
        row_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q    <= pixel_in_i;
      s1_col_q    <= c_cur;
      s1_emit_a_q <= (r_cur != '0) && (c_cur != '0);
      s1_emit_b_q <= (r_cur != '0) &&
                     (wss_pkg::FW_W'(c_cur) == w_eff - wss_pkg::FW_W'(1));
      s1_last_q   <= (r_cur == h_eff - wss_pkg::FH_W'(1));
      s1_top_q    <= (r_cur >= wss_pkg::FH_W'(2));
      s1_lft_q    <= (wss_pkg::FW_W'(c_cur) >= wss_pkg::FW_W'(2));
    end
  end

endmodule

// File: src/wss_evq.sv
// short event queue between front end and back end
module wss_evq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wss_pkg::event_t ev_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output wss_pkg::event_t ev_o
);

  localparam int PTR_W = $clog2(wss_pkg::EVQ_DEPTH);
  localparam int CNT_W = $clog2(wss_pkg::EVQ_DEPTH + 1);

  wss_pkg::event_t  slot_q [wss_pkg::EVQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(wss_pkg::EVQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign ev_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(wss_pkg::EVQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(wss_pkg::EVQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/wss_back.sv
// back end: output sequencing, weighted sum, constant divide and result queue
module wss_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ev_valid_i,
  input  wss_pkg::event_t           ev_i,
  output logic                      ev_pop_o,
  output logic                      empty,
  input  logic                      pop,
  output logic [wss_pkg::PIX_W-1:0] smoothed_o,
  output logic                      frame_last_o
);

  localparam int PTR_W = $clog2(wss_pkg::OFQ_DEPTH);
  localparam int CNT_W = $clog2(wss_pkg::OFQ_DEPTH + 1);

  logic [3:0] done_q, jobs, rem, pick, rest;
  logic       adv, issue;
  logic       low_row, right_col;
  logic       top, bot, lft, rgt;

  logic [2:0][wss_pkg::PIX_W-1:0] row_t, row_m, row_b;
  logic [wss_pkg::PIX_W-1:0] cc, en, es, ew, ee, cnw, cne, csw, cse;
  logic [9:0]                e_sum, k_sum;
  logic [wss_pkg::SUM_W-1:0] sum;
  wss_pkg::div_e             div;

  logic                      b1_v_q;
  logic [wss_pkg::SUM_W-1:0] b1_sum_q;
  wss_pkg::div_e             b1_div_q;
  logic                      b1_last_q;
  logic [wss_pkg::PROD_W-1:0] prod;

  wss_pkg::result_t ofq_q [wss_pkg::OFQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             of_full, of_push, of_pop;

  // pending outputs of the head event, in stream order
  assign jobs = {ev_i.emit_b & ev_i.last_row, ev_i.emit_b,
                 ev_i.emit_a & ev_i.last_row, ev_i.emit_a};
  assign rem  = jobs & ~done_q;
  assign pick = rem & (~rem + 4'd1);
  assign rest = rem & ~pick;

  assign of_full  = (cnt_q == CNT_W'(wss_pkg::OFQ_DEPTH));
  assign adv      = ~of_full;
  assign issue    = ev_valid_i & adv;
  assign ev_pop_o = issue & (rest == 4'd0);

  assign low_row   = pick[1] | pick[3];
  assign right_col = pick[2] | pick[3];
  assign top = low_row | ev_i.top_ok;
  assign bot = ~low_row;
  assign lft = right_col | ev_i.lft_ok;
  assign rgt = ~right_col;

  always_comb begin
    row_t = low_row ? ev_i.win[1] : ev_i.win[0];
    row_m = low_row ? ev_i.win[2] : ev_i.win[1];
    row_b = ev_i.win[2];
    cc  = right_col ? row_m[2] : row_m[1];
    en  = right_col ? row_t[2] : row_t[1];
    es  = right_col ? row_b[2] : row_b[1];
    ew  = right_col ? row_m[1] : row_m[0];
    ee  = row_m[2];
    cnw = right_col ? row_t[1] : row_t[0];
    cne = row_t[2];
    csw = right_col ? row_b[1] : row_b[0];
    cse = row_b[2];
    e_sum = 10'(en & {wss_pkg::PIX_W{top}}) + 10'(es & {wss_pkg::PIX_W{bot}}) +
            10'(ew & {wss_pkg::PIX_W{lft}}) + 10'(ee & {wss_pkg::PIX_W{rgt}});
    k_sum = 10'(cnw & {wss_pkg::PIX_W{top & lft}}) + 10'(cne & {wss_pkg::PIX_W{top & rgt}}) +
            10'(csw & {wss_pkg::PIX_W{bot & lft}}) + 10'(cse & {wss_pkg::PIX_W{bot & rgt}});
    sum = wss_pkg::SUM_W'(cc) * wss_pkg::SUM_W'(20) +
          wss_pkg::SUM_W'(e_sum) * wss_pkg::SUM_W'(10) +
          wss_pkg::SUM_W'(k_sum) * wss_pkg::SUM_W'(7);
    if (top && bot && lft && rgt) begin
      div = wss_pkg::DIV_88;
    end else if ((top && bot) || (lft && rgt)) begin
      div = wss_pkg::DIV_64;
    end else begin
      div = wss_pkg::DIV_47;
    end
  end

  assign prod    = wss_pkg::PROD_W'(b1_sum_q) * wss_pkg::PROD_W'(wss_pkg::recip(b1_div_q));
  assign of_push = adv & b1_v_q;
  assign of_pop  = pop & ~empty;

  assign empty        = (cnt_q == '0);
  assign smoothed_o   = ofq_q[rd_q].smoothed;
  assign frame_last_o = ofq_q[rd_q].frame_last;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_sum_q  <= sum;
      b1_div_q  <= div;
      b1_last_q <= pick[3];
    end
    if (of_push) begin
      ofq_q[wr_q].smoothed   <= prod[wss_pkg::RECIP_SHIFT +: wss_pkg::PIX_W];
      ofq_q[wr_q].frame_last <= b1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      b1_v_q <= 1'b0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (issue) begin
        done_q <= ev_pop_o ? 4'd0 : (done_q | pick);
      end
      if (adv) begin
        b1_v_q <= issue;
      end
      if (of_push) begin
        wr_q <= (wr_q == PTR_W'(wss_pkg::OFQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (of_pop) begin
        rd_q <= (rd_q == PTR_W'(wss_pkg::OFQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (of_push && !of_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (of_pop && !of_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/weighted_3x3_smoothing.sv
// top level of the weighted 3x3 smoothing block
// throughput: one pixel per cycle while full is low; the event queue absorbs the two
//   results of a row end; most last-row pixels carry two results, so full holds off push
// path: a result follows the transaction that completes its window through line store read,
//   window update, registered sum and divide into the result queue, where pop takes it
// reset: async active low; position, window and queues clear, width and height go to 8;
//   line stores are not cleared and need no clearing pass
module weighted_3x3_smoothing (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  logic [wss_pkg::PIX_W-1:0]          pixel_in_i,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic [wss_pkg::PIX_W-1:0]          smoothed_o,
  output logic                               frame_last_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // events carry the updated window plus which outputs it completes
  wss_pkg::event_t ev_in, ev_head;
  logic            ev_push, ev_pop, evq_full, evq_empty;

  // front end: raster position, two line stores, 3x3 window, output classes
  wss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_in_i  (pixel_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evq_full_i  (evq_full),
    .ev_push_o   (ev_push),
    .ev_o        (ev_in)
  );

  // decoupling queue: front keeps taking pixels while the back end drains a row end
  wss_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .ev_i    (ev_in),
    .full_o  (evq_full),
    .pop_i   (ev_pop),
    .empty_o (evq_empty),
    .ev_o    (ev_head)
  );

  // back end: one output per cycle while the result queue has room, through sum, reciprocal multiply and result queue
  wss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (~evq_empty),
    .ev_i         (ev_head),
    .ev_pop_o     (ev_pop),
    .empty        (empty),
    .pop          (pop),
    .smoothed_o   (smoothed_o),
    .frame_last_o (frame_last_o)
  );

  // event queue never overflows: front only pushes when there is room
  a_evq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push |-> !evq_full)
    else $error("event pushed into a full event queue");

  // back end only retires an event that is present
  a_evq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_pop |-> !evq_empty)
    else $error("event popped from an empty event queue");

  // only events that complete at least one output travel to the back end
  a_event_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push |-> (ev_in.emit_a || ev_in.emit_b))
    else $error("event without any output queued");

endmodule

// File: tb/weighted_3x3_smoothing_test.sv
// self-checking testbench for the weighted 3x3 smoothing block
module weighted_3x3_smoothing_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wss_pkg::*;

  // unused register indexes, writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam int RANDOM_ITEMS = 420;
  localparam int DRAIN_CYCLES = 10;
  localparam int END_CYCLES   = 20;
  localparam int LONG_HOLD    = 300;     // receiver stall that backs the block up
  localparam int LIMIT        = 200000;  // watchdog bound, far above the slowest correct run
  localparam int DIR_N        = 21;

  // ---------------------------------------------------------------------------
  // scoreboard: mirror of the line stores, window and raster position, plus the
  // queue of weighted means still owed by the block
  // ---------------------------------------------------------------------------
  class smoothing_scoreboard;
    logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [9];  // rows r-2, r-1, r by columns c-2, c-1, c
    int unsigned      col;
    int unsigned      row;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    result_t          expected_means[$];
    int               errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      errors     = 0;
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    // any write to a real register restarts the frame, stores keep their data
    function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
      else if (idx == REG_FRAME_HEIGHT) height_reg = data[FH_W-1:0];
      else return;
      col = 0;
      row = 0;
    endfunction

    // neighbors outside the frame drop out together with their weight
    function logic [PIX_W-1:0] weighted_mean(int unsigned cr, int unsigned cc,
                                             int unsigned y, int unsigned x,
                                             int unsigned w, int unsigned h);
      bit          up, dn, lf, rt;
      int unsigned e, k, dv, acc;
      up  = (y > 0) && (cr >= 1);
      dn  = (y + 1 < h) && (cr <= 1);
      lf  = (x > 0) && (cc >= 1);
      rt  = (x + 1 < w) && (cc <= 1);
      e   = 0;
      k   = 0;
      dv  = 20;
      acc = 20 * win[cr*3 + cc];
      if (up) begin e += win[(cr-1)*3 + cc]; dv += 10; end
      if (dn) begin e += win[(cr+1)*3 + cc]; dv += 10; end
      if (lf) begin e += win[cr*3 + cc - 1]; dv += 10; end
      if (rt) begin e += win[cr*3 + cc + 1]; dv += 10; end
      if (up && lf) begin k += win[(cr-1)*3 + cc - 1]; dv += 7; end
      if (up && rt) begin k += win[(cr-1)*3 + cc + 1]; dv += 7; end
      if (dn && lf) begin k += win[(cr+1)*3 + cc - 1]; dv += 7; end
      if (dn && rt) begin k += win[(cr+1)*3 + cc + 1]; dv += 7; end
      acc += 10 * e + 7 * k;
      return PIX_W'(acc / dv);
    endfunction

    function void add_result(logic [PIX_W-1:0] mean, logic last);
      result_t r;
      r.smoothed   = mean;
      r.frame_last = last;
      expected_means.push_back(r);
    endfunction

    // one accepted pixel: shift the window, rotate the line stores, queue outputs
    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned      w, h, c, r;
      logic [PIX_W-1:0] top_v, mid_v;
      w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 2) ? 2 : height_reg;
      c = (col >= w) ? 0 : col;
      r = (row >= h) ? 0 : row;
      top_v = line_mem[c];
      mid_v = line_mem[MAX_WIDTH + c];
      line_mem[c]             = mid_v;
      line_mem[MAX_WIDTH + c] = p;
      for (int i = 0; i < 3; i++) begin
        win[i*3]     = win[i*3 + 1];
        win[i*3 + 1] = win[i*3 + 2];
      end
      win[2] = top_v;
      win[5] = mid_v;
      win[8] = p;
      // last row comes out interleaved with the row above it
      if (r >= 1 && c >= 1) begin
        add_result(weighted_mean(1, 1, r - 1, c - 1, w, h), 1'b0);
        if (r == h - 1) add_result(weighted_mean(2, 1, r, c - 1, w, h), 1'b0);
      end
      if (r >= 1 && c == w - 1) begin
        add_result(weighted_mean(1, 2, r - 1, c, w, h), 1'b0);
        if (r == h - 1) add_result(weighted_mean(2, 2, r, c, w, h), 1'b1);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void check_result(logic [PIX_W-1:0] got_mean, logic got_last);
      result_t want;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual smoothed %0d frame_last %0b",
                 $time, got_mean, got_last);
        errors++;
        return;
      end
      want = expected_means.pop_front();
      if (got_mean !== want.smoothed) begin
        $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                 $time, want.smoothed, got_mean);
        errors++;
      end
      if (got_last !== want.frame_last) begin
        $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                 $time, want.frame_last, got_last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block signals
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  empty;
  logic                  pop;
  logic [PIX_W-1:0]      smoothed_o;
  logic                  frame_last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  smoothing_scoreboard sb;
  int unsigned         hold_off_reqs = 0;  // long receiver stalls asked for so far
  int unsigned         cycle_count   = 0;

  // directed frames: all-255 corners, an alternating 2x2, clamped sizes, a lone
  // bright center in a 3x3 that touches every kernel shape
  logic [PIX_W-1:0] dir_px [DIR_N] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0,
    8'd255, 8'd0, 8'd0, 8'd255,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weighted_3x3_smoothing dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_in_i   (pixel_in_i),
    .empty        (empty),
    .pop          (pop),
    .smoothed_o   (smoothed_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("weighted_3x3_smoothing_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks, all called from the rising edge
  // ---------------------------------------------------------------------------

  // register write, one cycle of enable, then enable low before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // push low for the gap, then hold push until the transaction goes through;
  // push stays high afterwards so back-to-back pixels see no bubble
  task automatic offer_pixel(input logic [PIX_W-1:0] v, input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    pixel_in_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_pixel(v);
  endtask

  // stop offering, wait for every owed result, then let the pipe run dry:
  // pixels of the top row leave work in flight with nothing queued
  task automatic settle_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: pops with random stalls, switching between busy and eager stretches
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    int unsigned holds_done;
    bit          rx_gappy;
    rx_gappy   = 1'b0;
    holds_done = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_reqs != holds_done) begin
        // long stall counted here while the sender keeps pushing
        holds_done++;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 23) == 0) rx_gappy = !rx_gappy;
        gap = rx_gappy ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_result(smoothed_o, frame_last_o);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed frames first, then random phases of frames
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, random_items, w_val, h_val, w_eff, h_eff, frame_px, n_items, gap;
    bit          tx_gappy, drain_mid;
    logic [PIX_W-1:0] px;
    sb           = new();
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    pixel_in_i   <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_FRAME_WIDTH;
    cfg_wdata_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored index, then the smallest frame twice over (wraps to a new frame)
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    for (int i = 0; i < 8; i++) offer_pixel(dir_px[i], 0);
    settle_idle();

    // width 0 and height 1 both clamp to 2; upper data bits must be masked off
    write_reg(REG_FRAME_WIDTH, {4'hF, 6'd0});
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
    for (int i = 8; i < 12; i++) offer_pixel(dir_px[i], 0);
    settle_idle();

    // 3x3 frame: interior, edge and corner kernels all at once
    write_reg(REG_SPARE_HI, CFG_DATA_W'(10'h155));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    for (int i = 12; i < DIR_N; i++) offer_pixel(dir_px[i], 0);
    settle_idle();

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // widest row, pushed flat out against a stalled receiver
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
        n_items       = MAX_WIDTH * 4;
        tx_gappy      = 1'b0;
        hold_off_reqs = hold_off_reqs + 1;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w_val = $urandom_range(2, 8);
            6:                w_val = MAX_WIDTH;
            7:                w_val = $urandom_range(9, MAX_WIDTH - 1);
            8:                w_val = $urandom_range(MAX_WIDTH + 1, 63);  // saturates
            default:          w_val = $urandom_range(0, 1);               // clamps up
          endcase
          write_reg(REG_FRAME_WIDTH, {4'($urandom), 6'(w_val)});
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: h_val = $urandom_range(2, 5);
            7:                   h_val = $urandom_range(0, 1);
            8:                   h_val = $urandom_range(6, 12);
            default:             h_val = 1023;  // only part of such a frame is sent
          endcase
          write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
        end
        if ($urandom_range(0, 7) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
        w_eff = (sb.width_reg < 2) ? 2 :
                ((sb.width_reg > MAX_WIDTH) ? MAX_WIDTH : sb.width_reg);
        h_eff = (sb.height_reg < 2) ? 2 : sb.height_reg;
        frame_px = w_eff * h_eff;
        // mostly whole frames, sometimes a cut-off frame
        if (frame_px <= 96 && $urandom_range(0, 4) != 0)
          n_items = frame_px * $urandom_range(1, 2);
        else
          n_items = $urandom_range(1, (frame_px < 96) ? frame_px : 96);
        // the last phase stops at the item budget
        if (n_items > RANDOM_ITEMS - random_items) n_items = RANDOM_ITEMS - random_items;
        tx_gappy = ($urandom_range(0, 2) != 0);
      end

      drain_mid = (phase == 1) || ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n_items; i++) begin
        // sender pause mid frame until every owed result is out
        if (drain_mid && i != 0 && i == n_items / 2) settle_idle();
        gap = tx_gappy ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? '1 : '0;
        else px = PIX_W'($urandom);
        offer_pixel(px, gap);
      end
      random_items += n_items;
      settle_idle();
      phase++;
    end

    // anything popping out now has no expectation and is flagged by the receiver
    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("weighted_3x3_smoothing_test passed");
    else
      $display("weighted_3x3_smoothing_test failed");
    $finish;
  end

endmodule

// File: weighted_3x3_smoothing.f
src/wss_pkg.sv
src/wss_ram.sv
src/wss_front.sv
src/wss_evq.sv
src/wss_back.sv
src/weighted_3x3_smoothing.sv
tb/weighted_3x3_smoothing_test.sv
